### hdl/swscm_pkg.sv
// shared constants, register indexes and command codes for the split-window change monitor
package swscm_pkg;

	localparam int MAX_WINDOW_DEF  = 256;
	localparam int SAMPLE_BITS_DEF = 16;

	localparam int HALF_W   = 8;
	localparam int THRESH_W = 23;
	localparam int DIFF_W   = 24;
	localparam int CFG_W    = 23;

	localparam logic [HALF_W-1:0]   HALF_RESET   = 8'd64;
	localparam logic [THRESH_W-1:0] THRESH_RESET = 23'd16384;

	localparam logic signed [DIFF_W-1:0] DIFF_MAX = 24'sh7FFFFF;
	localparam logic signed [DIFF_W-1:0] DIFF_MIN = 24'sh800000;

	typedef enum logic {
		REG_HALF_LENGTH     = 1'b0,
		REG_ALARM_THRESHOLD = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		OP_PUSH  = 1'b0,
		OP_CLEAR = 1'b1
	} op_t;

endpackage

### hdl/split_window_sum_change_monitor.sv
// split-window sum change monitor: top level with prefix-sum sample store
// Takes one command per clock unless in_stall is high (push a sample or clear the window) and
// returns one result per command through the stage-1 and output registers. Each store entry
// holds a sample and the running prefix sum up to it; a push writes one entry and reads two
// (H and 2H-1 samples back), and both half sums fall out of three prefix differences, so a
// changed half length takes effect at the next push with no rebuild. The store is read
// synchronously into stage 1; an alarm empties the window in time for the very next
// command. The store starts uninitialized and needs no clearing pass after reset.
module split_window_sum_change_monitor
	import swscm_pkg::*;
#(
	parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [0:0]                    cfg_addr,
	input  logic [CFG_W-1:0]              cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          op,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          alarm,
	output logic                          window_full,
	output logic signed [DIFF_W-1:0]      half_difference
);

	localparam int AW       = $clog2(MAX_WINDOW);
	localparam int DEPTH    = 1 << AW;
	localparam int FW       = $clog2(MAX_WINDOW + 1);
	localparam int HALF_CAP = (MAX_WINDOW / 2 < 255) ? MAX_WINDOW / 2 : 255;
	localparam int SUM_W    = SAMPLE_BITS + HALF_W + 1;
	localparam int WORD_W   = SUM_W + SAMPLE_BITS;
	localparam int EXT_W    = (SUM_W > DIFF_W) ? SUM_W : DIFF_W;
	localparam int CMP_W    = (SUM_W > THRESH_W) ? SUM_W : THRESH_W;

	logic [HALF_W-1:0]   half_q;
	logic [THRESH_W-1:0] thresh_q;
	logic [HALF_W-1:0]   h_eff;
	logic [FW-1:0]       len;
	logic [AW-1:0]       addr_a;
	logic [AW-1:0]       addr_b;

	logic [AW-1:0]           wp_q;
	logic [FW-1:0]           fill_q;
	logic signed [SUM_W-1:0] total_q;

	logic in_xfer;
	logic is_push;
	logic adv_s1;

	logic signed [SUM_W-1:0] sample_ext;
	logic signed [SUM_W-1:0] prefix_new;
	logic [FW-1:0]           fill_base;
	logic [FW:0]             fill_inc;
	logic [FW-1:0]           fill_push;

	logic [WORD_W-1:0] store_mem [DEPTH];

	logic                    valid_s1;
	logic                    full_s1;
	logic signed [SUM_W-1:0] total_s1;
	logic [SUM_W-1:0]        rd_a_s1;
	logic [WORD_W-1:0]       rd_b_s1;

	logic signed [SUM_W-1:0]  pa;
	logic signed [SUM_W-1:0]  pb;
	logic signed [SUM_W-1:0]  sb_ext;
	logic signed [SUM_W-1:0]  newer;
	logic signed [SUM_W-1:0]  older;
	logic signed [SUM_W-1:0]  diff;
	logic [SUM_W-1:0]         mag;
	logic signed [EXT_W-1:0]  diff_ext;
	logic signed [DIFF_W-1:0] diff_out;
	logic                     alarm_s1;

	logic                     out_valid_q;
	logic                     alarm_q;
	logic                     full_q;
	logic signed [DIFF_W-1:0] diff_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q   <= HALF_RESET;
			thresh_q <= THRESH_RESET;
		end else if (cfg_write) begin
			if (cfg_addr == REG_HALF_LENGTH) begin
				half_q <= cfg_data[HALF_W-1:0];
			end
			if (cfg_addr == REG_ALARM_THRESHOLD) begin
				thresh_q <= cfg_data[THRESH_W-1:0];
			end
		end
	end

	always_comb begin
		if (half_q == '0) begin
			h_eff = HALF_W'(1);
		end else if (half_q > HALF_W'(HALF_CAP)) begin
			h_eff = HALF_W'(HALF_CAP);
		end else begin
			h_eff = half_q;
		end
	end

	assign len    = FW'({h_eff, 1'b0});
	// entry H back closes the older half, entry 2H-1 back is the oldest in the window
	assign addr_a = wp_q - AW'(h_eff);
	assign addr_b = wp_q - AW'({h_eff, 1'b0} - 9'd1);

	// handshake
	assign adv_s1   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv_s1;
	assign in_xfer  = in_valid && !in_stall;
	assign is_push  = in_xfer && (op == OP_PUSH);

	assign sample_ext = SUM_W'(sample);
	assign prefix_new = total_q + sample_ext;

	// an alarm leaving stage 1 empties the window before this transfer is counted
	assign fill_base = (adv_s1 && alarm_s1) ? '0 : fill_q;
	assign fill_inc  = {1'b0, fill_base} + 1'b1;
	assign fill_push = (fill_inc > {1'b0, len}) ? len : fill_inc[FW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= '0;
			fill_q   <= '0;
			total_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (in_xfer) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (is_push) begin
				wp_q    <= wp_q + 1'b1;
				total_q <= prefix_new;
				fill_q  <= fill_push;
			end else if (in_xfer) begin
				fill_q <= '0;
			end else begin
				fill_q <= fill_base;
			end
		end
	end

	// sample store: two reads per transfer and one write per push, never the same entry
	always_ff @(posedge clk) begin
		if (is_push) begin
			store_mem[wp_q] <= {prefix_new, sample};
		end
		if (in_xfer) begin
			rd_a_s1  <= store_mem[addr_a][WORD_W-1:SAMPLE_BITS];
			rd_b_s1  <= store_mem[addr_b];
			total_s1 <= prefix_new;
			full_s1  <= is_push && (fill_push == len);
		end
	end

	// stage 1: half sums from prefix differences
	assign pa     = rd_a_s1;
	assign pb     = rd_b_s1[WORD_W-1:SAMPLE_BITS];
	assign sb_ext = SUM_W'($signed(rd_b_s1[SAMPLE_BITS-1:0]));
	assign newer  = total_s1 - pa;
	assign older  = pa - (pb - sb_ext);
	assign diff   = newer - older;
	assign mag    = diff[SUM_W-1] ? -diff : diff;

	assign alarm_s1 = full_s1 && (CMP_W'(mag) > CMP_W'(thresh_q));
	assign diff_ext = EXT_W'(diff);

	always_comb begin
		if (!full_s1) begin
			diff_out = '0;
		end else if (diff_ext > EXT_W'(DIFF_MAX)) begin
			diff_out = DIFF_MAX;
		end else if (diff_ext < EXT_W'(DIFF_MIN)) begin
			diff_out = DIFF_MIN;
		end else begin
			diff_out = diff_ext[DIFF_W-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			alarm_q <= alarm_s1;
			full_q  <= full_s1;
			diff_q  <= diff_out;
		end
	end

	assign out_valid       = out_valid_q;
	assign alarm           = alarm_q;
	assign window_full     = full_q;
	assign half_difference = diff_q;

endmodule

### hdl/swscm_checker.sv
// port-level checker for the split-window change monitor, bound to the top level
module swscm_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic               alarm,
	input logic               window_full,
	input logic signed [23:0] half_difference
);

	// a stalled result stays and holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(alarm) && $stable(window_full)
			&& $stable(half_difference))
		else $error("stalled result changed");

	// no full window means a zero result with no alarm
	a_not_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !window_full |-> !alarm && (half_difference == 24'sd0))
		else $error("result without full window is not zero");

	a_alarm_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && alarm |-> window_full)
		else $error("alarm without full window");

	// input backs up only when the output side is stalled
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |-> out_valid && out_stall)
		else $error("input stalled while output is free");

	// flops clear asynchronously in reset, so no result and no stall follow
	a_reset_idle: assert property (@(posedge clk)
		!arst_n |=> !out_valid && !in_stall)
		else $error("activity during reset");

endmodule

bind split_window_sum_change_monitor swscm_checker u_swscm_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_stall        (in_stall),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.alarm           (alarm),
	.window_full     (window_full),
	.half_difference (half_difference)
);

### dv/split_window_sum_change_monitor_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the split-window sum change monitor
module split_window_sum_change_monitor_tb;
	import swscm_pkg::*;

	localparam int HALF_MAX   = MAX_WINDOW_DEF / 2;
	localparam int ITEM_GOAL  = 1650;
	localparam int LONG_HOLD  = 120;
	localparam int WAIT_MAX   = 10;
	localparam int SAMPLE_MAX = 32767;
	localparam int SAMPLE_MIN = -32768;
	localparam logic [THRESH_W-1:0] THRESH_MAX = '1;

	typedef enum int {
		PACE_FULL_RATE,
		PACE_RANDOM,
		PACE_SPARSE
	} pace_t;

	typedef struct {
		op_t                               op;
		logic signed [SAMPLE_BITS_DEF-1:0] sample;
		int                                gap;
	} window_cmd_t;

	typedef struct {
		logic                     alarm;
		logic                     window_full;
		logic signed [DIFF_W-1:0] half_difference;
	} change_result_t;

	logic                              clk;
	logic                              arst_n    = 1'b0;
	logic                              cfg_write = 1'b0;
	cfg_reg_t                          cfg_addr  = REG_HALF_LENGTH;
	logic [CFG_W-1:0]                  cfg_data  = '0;
	logic                              in_valid  = 1'b0;
	logic                              in_stall;
	op_t                               op        = OP_PUSH;
	logic signed [SAMPLE_BITS_DEF-1:0] sample    = '0;
	logic                              out_valid;
	logic                              out_stall = 1'b0;
	logic                              alarm;
	logic                              window_full;
	logic signed [DIFF_W-1:0]          half_difference;

	// predictor state
	logic signed [SAMPLE_BITS_DEF-1:0] win_store [MAX_WINDOW_DEF];
	int                                win_fill;
	int                                win_wr_ptr;
	logic [HALF_W-1:0]                 half_reg   = HALF_RESET;
	logic [THRESH_W-1:0]               thresh_reg = THRESH_RESET;

	window_cmd_t    cmd_queue[$];
	change_result_t pending_results[$];
	change_result_t want;
	window_cmd_t    cur_cmd;
	bit             cmd_loaded;
	int             gap_left;
	bit             in_taken;
	bit             out_taken;
	int             rx_wait;
	int             hold_left;
	bit             hold_req;
	pace_t          tx_pace = PACE_RANDOM;
	pace_t          rx_pace = PACE_RANDOM;
	int             items_queued;
	int             mismatch_count;

	split_window_sum_change_monitor i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_addr       (cfg_addr),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.op             (op),
		.sample         (sample),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.alarm          (alarm),
		.window_full    (window_full),
		.half_difference(half_difference)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("simulation failed");
		$finish;
	end

	function automatic change_result_t predict_change_result(op_t cmd,
			logic signed [SAMPLE_BITS_DEF-1:0] smp);
		change_result_t r;
		int             h;
		int             len;
		int             idx;
		longint         newer;
		longint         older;
		longint         diff;
		longint         mag;
		r = '{alarm: 1'b0, window_full: 1'b0, half_difference: '0};
		h = (half_reg == 0) ? 1 : ((half_reg > HALF_MAX) ? HALF_MAX : int'(half_reg));
		len = 2 * h;
		if (cmd == OP_CLEAR) begin
			win_fill = 0;
			win_wr_ptr = 0;
			return r;
		end
		win_store[win_wr_ptr] = smp;
		win_wr_ptr = (win_wr_ptr + 1) % MAX_WINDOW_DEF;
		win_fill++;
		// a shrunk window drops its oldest samples here
		if (win_fill > len)
			win_fill = len;
		if (win_fill < len)
			return r;
		newer = 0;
		older = 0;
		for (int k = 0; k < len; k++) begin
			idx = (win_wr_ptr + MAX_WINDOW_DEF - 1 - k) % MAX_WINDOW_DEF;
			if (k < h)
				newer += win_store[idx];
			else
				older += win_store[idx];
		end
		diff = newer - older;
		mag = (diff < 0) ? -diff : diff;
		r.alarm = (mag > longint'(thresh_reg));
		r.window_full = 1'b1;
		if (diff > longint'(DIFF_MAX))
			diff = longint'(DIFF_MAX);
		if (diff < longint'(DIFF_MIN))
			diff = longint'(DIFF_MIN);
		r.half_difference = diff[DIFF_W-1:0];
		if (r.alarm) begin
			win_fill = 0;
			win_wr_ptr = 0;
		end
		return r;
	endfunction

	function automatic int draw_wait(pace_t pace);
		case (pace)
			PACE_FULL_RATE: return 0;
			PACE_RANDOM:    return $urandom_range(0, WAIT_MAX);
			default:        return ($urandom_range(0, 4) == 0) ? $urandom_range(1, WAIT_MAX) : 0;
		endcase
	endfunction

	// transfer sampling, prediction and result check
	always @(posedge clk) begin
		in_taken = arst_n && in_valid && !in_stall;
		out_taken = arst_n && out_valid && !out_stall;
		if (out_taken) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result: expected none, got alarm %b full %b diff %0d",
					$time, alarm, window_full, half_difference);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (alarm !== want.alarm) begin
					$display("%0t: alarm expected %b got %b", $time, want.alarm, alarm);
					mismatch_count++;
				end
				if (window_full !== want.window_full) begin
					$display("%0t: window_full expected %b got %b", $time,
						want.window_full, window_full);
					mismatch_count++;
				end
				if (half_difference !== want.half_difference) begin
					$display("%0t: half_difference expected %0d got %0d", $time,
						want.half_difference, half_difference);
					mismatch_count++;
				end
			end
		end
		if (in_taken)
			pending_results = {pending_results, predict_change_result(op, sample)};
	end

	// command driver
	always @(negedge clk) begin
		if (!in_valid || in_taken) begin
			if (!cmd_loaded && cmd_queue.size() > 0) begin
				cur_cmd = cmd_queue.pop_front();
				cmd_loaded = 1'b1;
				gap_left = cur_cmd.gap;
			end
			if (cmd_loaded && gap_left == 0) begin
				in_valid <= 1'b1;
				op <= cur_cmd.op;
				sample <= cur_cmd.sample;
				cmd_loaded = 1'b0;
			end else begin
				in_valid <= 1'b0;
				if (cmd_loaded)
					gap_left--;
			end
		end
	end

	// result receiver stall
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = LONG_HOLD;
			hold_req = 1'b0;
		end
		if (out_taken)
			rx_wait = draw_wait(rx_pace);
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (rx_wait > 0) begin
			out_stall <= 1'b1;
			rx_wait--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic queue_cmd(op_t c, int value);
		window_cmd_t w;
		w.op = c;
		w.sample = value[SAMPLE_BITS_DEF-1:0];
		w.gap = draw_wait(tx_pace);
		cmd_queue = {cmd_queue, w};
		items_queued++;
	endtask

	task automatic wait_idle();
		do begin
			@(posedge clk);
			#1;
		end while (cmd_queue.size() != 0 || cmd_loaded || in_valid
			|| pending_results.size() != 0);
	endtask

	task automatic write_reg(cfg_reg_t idx, int value);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= CFG_W'(value);
		if (idx == REG_HALF_LENGTH)
			half_reg = HALF_W'(value);
		else
			thresh_reg = THRESH_W'(value);
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	function automatic int clip_sample(int v);
		if (v > SAMPLE_MAX)
			return SAMPLE_MAX;
		if (v < SAMPLE_MIN)
			return SAMPLE_MIN;
		return v;
	endfunction

	function automatic int pick_level();
		case ($urandom_range(0, 5))
			0:       return SAMPLE_MAX;
			1:       return SAMPLE_MIN;
			default: return int'($urandom_range(0, 48000)) - 24000;
		endcase
	endfunction

	// extreme samples at the largest window, ending in an alarm at full magnitude
	task automatic extreme_window_run();
		tx_pace = PACE_SPARSE;
		rx_pace = PACE_RANDOM;
		write_reg(REG_HALF_LENGTH, 255);
		write_reg(REG_ALARM_THRESHOLD, int'(THRESH_MAX));
		queue_cmd(OP_CLEAR, 0);
		repeat (HALF_MAX) queue_cmd(OP_PUSH, SAMPLE_MIN);
		repeat (HALF_MAX) queue_cmd(OP_PUSH, SAMPLE_MAX);
		repeat (HALF_MAX - 1) queue_cmd(OP_PUSH, SAMPLE_MIN);
		wait_idle();
		write_reg(REG_ALARM_THRESHOLD, 8388479);
		queue_cmd(OP_PUSH, SAMPLE_MIN);
		wait_idle();
	endtask

	// level segments with noise, level shifts around once per window
	task automatic random_window_run();
		int pick;
		int h;
		int eff;
		int n;
		int amp;
		int level;
		int r;
		pick = $urandom_range(0, 31);
		if (pick == 0)
			h = 0;
		else if (pick == 1)
			h = $urandom_range(HALF_MAX + 1, 255);
		else if (pick == 2)
			h = $urandom_range(41, HALF_MAX);
		else if (pick <= 8)
			h = $urandom_range(9, 40);
		else
			h = $urandom_range(1, 8);
		if ($urandom_range(0, 9) < 7)
			write_reg(REG_HALF_LENGTH, h);
		eff = (half_reg == 0) ? 1 : ((half_reg > HALF_MAX) ? HALF_MAX : int'(half_reg));
		case ($urandom_range(0, 9))
			0:       write_reg(REG_ALARM_THRESHOLD, 0);
			1:       write_reg(REG_ALARM_THRESHOLD, int'(THRESH_MAX));
			2:       write_reg(REG_ALARM_THRESHOLD, $urandom_range(0, THRESH_MAX));
			3:       ;
			default: write_reg(REG_ALARM_THRESHOLD, $urandom_range(0, eff * 6000));
		endcase
		tx_pace = pace_t'($urandom_range(0, 2));
		rx_pace = pace_t'($urandom_range(0, 2));
		amp = ($urandom_range(0, 3) == 0) ? $urandom_range(0, SAMPLE_MAX) : $urandom_range(0, 2000);
		level = pick_level();
		n = $urandom_range(20, 60) + 2 * eff * $urandom_range(1, 2);
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < 3) begin
				queue_cmd(OP_CLEAR, $urandom);
			end else if (r < 8) begin
				queue_cmd(OP_PUSH, $urandom);
			end else begin
				if ($urandom_range(0, 2 * eff) == 0)
					level = pick_level();
				queue_cmd(OP_PUSH, clip_sample(level + int'($urandom_range(0, 2 * amp)) - amp));
			end
		end
		wait_idle();
	endtask

	initial begin : stimulus
		int run_no;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// register defaults, window never fills, then clear
		queue_cmd(OP_PUSH, SAMPLE_MAX);
		queue_cmd(OP_PUSH, SAMPLE_MIN);
		queue_cmd(OP_PUSH, 0);
		queue_cmd(OP_CLEAR, 0);
		wait_idle();

		// smallest window, zero threshold: alarms on any change
		write_reg(REG_HALF_LENGTH, 1);
		write_reg(REG_ALARM_THRESHOLD, 0);
		queue_cmd(OP_PUSH, SAMPLE_MAX);
		queue_cmd(OP_PUSH, SAMPLE_MIN);
		queue_cmd(OP_PUSH, 0);
		queue_cmd(OP_PUSH, 0);
		queue_cmd(OP_PUSH, 0);
		queue_cmd(OP_CLEAR, 0);
		queue_cmd(OP_PUSH, SAMPLE_MIN);
		queue_cmd(OP_PUSH, SAMPLE_MAX);
		wait_idle();

		// half length zero acts as one; difference equal to threshold does not alarm
		write_reg(REG_HALF_LENGTH, 0);
		write_reg(REG_ALARM_THRESHOLD, 2);
		queue_cmd(OP_PUSH, 5);
		queue_cmd(OP_PUSH, 7);
		queue_cmd(OP_PUSH, 4);
		wait_idle();

		// oversized half length, window still filling
		write_reg(REG_HALF_LENGTH, 200);
		queue_cmd(OP_PUSH, 1);
		queue_cmd(OP_PUSH, -1);
		queue_cmd(OP_PUSH, SAMPLE_MAX);
		queue_cmd(OP_PUSH, SAMPLE_MIN);
		wait_idle();

		extreme_window_run();

		while (items_queued < ITEM_GOAL) begin
			random_window_run();
			run_no++;
			if (run_no == 3) begin
				// receiver holds off while the sender keeps offering at full rate
				hold_req = 1'b1;
				tx_pace = PACE_FULL_RATE;
				repeat (40) queue_cmd(OP_PUSH, $urandom);
				wait_idle();
			end
		end

		wait_idle();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
